/* hdl/lrdpq_pkg.sv */
`default_nettype none
package lrdpq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TAG_W   = 16;
  localparam int BITS_W  = 11;
  localparam int CYCLE_W = 48;
  localparam int OCC_W   = 16;
  localparam int LW_W    = 7;
  localparam int DR_W    = 8;
  localparam int LIM_W   = 14;
  localparam int DIV_N_W = $clog2(BITS_W);

  localparam logic [LW_W-1:0]  LINK_WIDTH_RESET      = LW_W'(4);
  localparam logic [DR_W-1:0]  DRAIN_RATE_RESET      = DR_W'(30);
  localparam logic [LIM_W-1:0] OCCUPANCY_LIMIT_RESET = LIM_W'(120);

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [BITS_W-1:0]  bits_t;
  typedef logic [CYCLE_W-1:0] cycle_t;
  typedef logic [OCC_W-1:0]   occ_t;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_FRONT = 2'd2,
    FUNC_POP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_LINK_WIDTH      = 2'd0,
    CFG_DRAIN_RATE      = 2'd1,
    CFG_OCCUPANCY_LIMIT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    func_t  func;
    tag_t   packet_tag;
    bits_t  packet_bits;
    cycle_t current_cycle;
  } req_t;

  typedef struct packed {
    logic  accepted;
    logic  head_ready;
    tag_t  head_tag;
    bits_t head_bits;
    logic  became_busy;
    logic  became_idle;
    logic  empty_error;
  } rsp_t;

  typedef struct packed {
    cfg_index_t       index;
    logic [LIM_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    tag_t   tag;
    bits_t  bits;
    cycle_t cycle;
  } meta_t;

  function automatic ptr_t next_slot(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

/* hdl/lrdpq_if.sv */
`default_nettype none
interface lrdpq_req_if;
  import lrdpq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrdpq_rsp_if;
  import lrdpq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrdpq_cfg_if;
  import lrdpq_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/link_rate_drained_packet_queue.sv */
// Channel | Dir | Payload                                    | Accepted when
// req     | in  | func, packet_tag, packet_bits, current_cyc | req.valid & req.ready
// rsp     | out | accepted, head_ready, head_tag, head_bits, | rsp.valid & rsp.ready
//         |     | became_busy, became_idle, empty_error      |
// cfg     | in  | index, value                               | cfg.valid & cfg.ready
//
// One word at a time. Query, reject and empty access go straight to the finish
// state; pop passes the metadata state. Push runs the bit-serial divider for the
// cost (one bit a cycle). Front read-modify-writes the cost memory per entry.
// Synchronous reset clears pointers, counts and occupancy; no clearing pass.
// A held result in the output register stalls only the finish of the next word.
`default_nettype none
module link_rate_drained_packet_queue (
  input wire logic    clk,
  input wire logic    rst,
  lrdpq_req_if.sink   req,
  lrdpq_rsp_if.source rsp,
  lrdpq_cfg_if.sink   cfg
);
  import lrdpq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_META,
    ST_RD,
    ST_EV,
    ST_FIN
  } state_t;

  state_t           state;
  req_t             hold;
  rsp_t             res;
  rsp_t             res_init;
  rsp_t             out_data;
  logic             out_valid;
  ptr_t             head_pointer;
  ptr_t             tail_pointer;
  cnt_t             entry_count;
  occ_t             occupancy;
  logic [LW_W-1:0]  link_width;
  logic [DR_W-1:0]  drain_rate;
  logic [LIM_W-1:0] occupancy_limit;

  logic [DR_W-1:0]    budget;
  ptr_t               walk_ptr;
  cnt_t               walk_n;
  logic               head_zero;
  bits_t              dvd;
  logic [LW_W-1:0]    rmd;
  bits_t              quot;
  logic [LW_W-1:0]    dsr;
  logic [DIV_N_W-1:0] div_n;

  meta_t meta_mem [QUEUE_DEPTH];
  bits_t rem_mem [QUEUE_DEPTH];
  meta_t meta_q;
  bits_t rem_q;

  logic  meta_we, meta_re, rem_we, rem_re;
  ptr_t  meta_ra, rem_wa;
  bits_t rem_wd;

  logic          req_fire, cfg_fire, has_room, div_last, fin_go;
  logic [LW_W:0] div_t, div_sub;
  logic          div_ge;
  bits_t         quot_next;
  logic          ev_over, ev_done, ev_head_zero;
  bits_t         ev_diff;
  cnt_t          walk_n_next;

  assign req.ready = !rst && (state == ST_IDLE);
  assign cfg.ready = !rst;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign req_fire = req.valid && req.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign has_room = (occupancy < OCC_W'(occupancy_limit)) &&
                    (entry_count < CNT_W'(QUEUE_DEPTH));
  assign fin_go   = (state == ST_FIN) && (!out_valid || rsp.ready);

  assign div_t     = {rmd, dvd[BITS_W-1]};
  assign div_ge    = (div_t >= {1'b0, dsr});
  assign div_sub   = div_t - {1'b0, dsr};
  assign quot_next = {quot[BITS_W-2:0], div_ge};
  assign div_last  = (div_n == DIV_N_W'(BITS_W - 1));

  assign ev_over      = (rem_q > BITS_W'(budget));
  assign ev_diff      = rem_q - BITS_W'(budget);
  assign walk_n_next  = walk_n + CNT_W'(1);
  assign ev_done      = ev_over || (walk_n_next == entry_count);
  assign ev_head_zero = (walk_n == '0) ? !ev_over : head_zero;

  always_comb begin
    res_init = '0;
    case (req.data.func)
      FUNC_PUSH: begin
        res_init.accepted    = has_room;
        res_init.became_busy = has_room && (occupancy == '0);
      end
      FUNC_QUERY: res_init.accepted = has_room;
      default:    res_init.empty_error = (entry_count == '0);
    endcase
  end

  always_comb begin
    meta_we = (state == ST_DIV) && div_last;
    meta_re = req_fire;
    meta_ra = head_pointer;
    rem_re  = (state == ST_RD);
    rem_we  = 1'b0;
    rem_wa  = tail_pointer;
    rem_wd  = quot_next;
    if (state == ST_DIV && div_last) begin
      rem_we = 1'b1;
    end else if (state == ST_EV) begin
      rem_we = 1'b1;
      rem_wa = walk_ptr;
      rem_wd = ev_over ? ev_diff : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[tail_pointer] <= '{tag: hold.packet_tag, bits: hold.packet_bits,
                                  cycle: hold.current_cycle};
    end
    if (meta_re) begin
      meta_q <= meta_mem[meta_ra];
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (rem_re) begin
      rem_q <= rem_mem[walk_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      head_pointer    <= '0;
      tail_pointer    <= '0;
      entry_count     <= '0;
      occupancy       <= '0;
      link_width      <= LINK_WIDTH_RESET;
      drain_rate      <= DRAIN_RATE_RESET;
      occupancy_limit <= OCCUPANCY_LIMIT_RESET;
    end else begin
      if (cfg_fire) begin
        case (cfg.data.index)
          CFG_LINK_WIDTH:      link_width      <= cfg.data.value[LW_W-1:0];
          CFG_DRAIN_RATE:      drain_rate      <= cfg.data.value[DR_W-1:0];
          CFG_OCCUPANCY_LIMIT: occupancy_limit <= cfg.data.value;
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            hold <= req.data;
            res  <= res_init;
            case (req.data.func)
              FUNC_PUSH: begin
                if (has_room) begin
                  dvd   <= req.data.packet_bits;
                  rmd   <= '0;
                  quot  <= '0;
                  div_n <= '0;
                  dsr   <= (link_width == '0) ? LW_W'(1) : link_width;
                  state <= ST_DIV;
                end else begin
                  state <= ST_FIN;
                end
              end
              FUNC_QUERY: begin
                state <= ST_FIN;
              end
              default: begin
                if (entry_count == '0) begin
                  state <= ST_FIN;
                end else if (req.data.func == FUNC_FRONT) begin
                  budget   <= drain_rate;
                  walk_ptr <= head_pointer;
                  walk_n   <= '0;
                  state    <= ST_RD;
                end else begin
                  state <= ST_META;
                end
              end
            endcase
          end
        end
        ST_DIV: begin
          dvd   <= {dvd[BITS_W-2:0], 1'b0};
          rmd   <= div_ge ? div_sub[LW_W-1:0] : div_t[LW_W-1:0];
          quot  <= quot_next;
          div_n <= div_n + DIV_N_W'(1);
          if (div_last) begin
            occupancy    <= occupancy + OCC_W'(quot_next);
            tail_pointer <= next_slot(tail_pointer);
            entry_count  <= entry_count + CNT_W'(1);
            state        <= ST_FIN;
          end
        end
        ST_META: begin
          res <= '{accepted: 1'b0, head_ready: 1'b0, head_tag: meta_q.tag,
                   head_bits: meta_q.bits, became_busy: 1'b0,
                   became_idle: (entry_count == CNT_W'(1)), empty_error: 1'b0};
          head_pointer <= next_slot(head_pointer);
          entry_count  <= entry_count - CNT_W'(1);
          state        <= ST_FIN;
        end
        ST_RD: begin
          state <= ST_EV;
        end
        ST_EV: begin
          head_zero <= ev_head_zero;
          if (ev_over) begin
            occupancy <= occupancy - OCC_W'(budget);
          end else begin
            occupancy <= occupancy - OCC_W'(rem_q);
            budget    <= budget - rem_q[DR_W-1:0];
            walk_ptr  <= next_slot(walk_ptr);
            walk_n    <= walk_n_next;
          end
          if (ev_done) begin
            res <= '{accepted: 1'b0,
                     head_ready: ev_head_zero && (meta_q.cycle != hold.current_cycle),
                     head_tag: meta_q.tag, head_bits: meta_q.bits, became_busy: 1'b0,
                     became_idle: 1'b0, empty_error: 1'b0};
            state <= ST_FIN;
          end else begin
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_data <= res;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> (head_pointer == tail_pointer))
    else $error("empty queue with head and tail apart");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EV) |-> (walk_n < entry_count))
    else $error("drain walk past the queued entries");

  a_busy_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.became_busy) |-> out_data.accepted)
    else $error("busy flag on a word that was not accepted");

  a_walk_on_front: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (hold.func == FUNC_FRONT && entry_count != '0))
    else $error("drain walk outside a front request");
`endif
endmodule
`default_nettype wire
